// File: rtl/planar_rle_sprite_decoder_core_assert.svh
`ifndef PLANAR_RLE_SPRITE_DECODER_CORE_ASSERT_SVH
`define PLANAR_RLE_SPRITE_DECODER_CORE_ASSERT_SVH

// Checks that a condition implies another in the same cycle.
`define PRSD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition implies another in the next cycle.
`define PRSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/prsd_pkg.sv
package prsd_pkg;

    localparam int unsigned PLANES = 4;
    localparam logic [1:0] LAST_PLANE = 2'(PLANES - 1);

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_DECODE = 2'd1
    } t_phase;

    typedef struct packed {
        logic [15:0] pixel_address;
        logic [7:0]  pixel_value;
        logic        is_write;
        logic        out_of_range;
        logic        sprite_done;
    } t_result;

endpackage

// File: rtl/planar_rle_sprite_decoder_core.sv
// Decodes a planar run-length sprite at one byte per clock unless the input is stalled.
// Each accepted byte updates the decoder state in the same cycle; its result, if any, is
// registered into the output register, or into the skid register while the output is
// stalled. A two-entry output stage (output register plus skid register) lets the
// block keep taking bytes while a result waits in the output register; the input is
// stalled only while the skid register is full. The width times height frame limit
// comes from a registered multiplier that settles before the first literal pixel arrives.
`include "planar_rle_sprite_decoder_core_assert.svh"

module planar_rle_sprite_decoder_core #(
    parameter int unsigned FRAME_PIXELS = 65536,
    parameter int unsigned HEADER_BYTES = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_sprite_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_pixel_address,
    output logic [7:0]  o_pixel_value,
    output logic        o_is_write,
    output logic        o_out_of_range,
    output logic        o_sprite_done
);

    localparam int unsigned HC_W = $clog2(HEADER_BYTES);
    localparam logic [HC_W-1:0] HC_LAST = HC_W'(HEADER_BYTES - 1);
    localparam logic [32:0] FRAME_LIMIT = 33'(FRAME_PIXELS);

    prsd_pkg::t_phase  r_phase, n_phase;
    logic [HC_W-1:0]   r_hcnt, n_hcnt;
    logic [15:0]       r_width, n_width;
    logic [15:0]       r_height, n_height;
    logic [1:0]        r_plane, n_plane;
    logic [15:0]       r_rows, n_rows;
    logic [31:0]       r_row_base, n_row_base;
    logic [31:0]       r_cursor, n_cursor;
    logic [6:0]        r_lit, n_lit;
    logic [31:0]       r_limit;

    logic              r_ov, r_sv;
    prsd_pkg::t_result r_out, r_skid, res;
    logic              res_v;

    logic              acc, out_free;
    logic [32:0]       lit_sum, skip_sum, base_sum;
    logic [33:0]       cur_sum;
    logic [10:0]       skip_len;
    logic [31:0]       lit_cursor, skip_cursor, base_sat, row_cursor;
    logic [15:0]       rows_dec;
    logic              hdr_last, row_end, plane_end, bad;

    assign acc      = i_in_valid && !r_sv;
    assign out_free = !r_ov || !i_out_stall;

    assign hdr_last  = (r_phase == prsd_pkg::PH_HEADER) && (r_hcnt == HC_LAST);
    assign row_end   = (r_phase == prsd_pkg::PH_DECODE) && (r_lit == 7'd0)
                       && (i_sprite_byte == 8'd0);
    assign rows_dec  = r_rows - 16'd1;
    assign plane_end = row_end && (rows_dec == 16'd0);

    assign skip_len    = {(9'd256 - {1'b0, i_sprite_byte}), 2'b00};
    assign lit_sum     = {1'b0, r_cursor} + 33'd4;
    assign skip_sum    = {1'b0, r_cursor} + {22'd0, skip_len};
    assign base_sum    = {1'b0, r_row_base} + {17'd0, r_width};
    assign cur_sum     = {2'b00, r_row_base} + {18'd0, r_width} + {32'd0, r_plane};
    assign lit_cursor  = lit_sum[32]  ? 32'hFFFF_FFFF : lit_sum[31:0];
    assign skip_cursor = skip_sum[32] ? 32'hFFFF_FFFF : skip_sum[31:0];
    assign base_sat    = base_sum[32] ? 32'hFFFF_FFFF : base_sum[31:0];
    assign row_cursor  = (cur_sum[33:32] != 2'b00) ? 32'hFFFF_FFFF : cur_sum[31:0];

    assign bad = (r_cursor >= r_limit) || ({1'b0, r_cursor} >= FRAME_LIMIT);

    always_comb begin
        n_phase    = r_phase;
        n_hcnt     = r_hcnt;
        n_width    = r_width;
        n_height   = r_height;
        n_plane    = r_plane;
        n_rows     = r_rows;
        n_row_base = r_row_base;
        n_cursor   = r_cursor;
        n_lit      = r_lit;
        if (r_phase != prsd_pkg::PH_DECODE) begin
            case (r_hcnt)
                HC_W'(0): n_width  = {r_width[15:8], i_sprite_byte};
                HC_W'(1): n_width  = {i_sprite_byte, r_width[7:0]};
                HC_W'(2): n_height = {r_height[15:8], i_sprite_byte};
                HC_W'(3): n_height = {i_sprite_byte, r_height[7:0]};
                default: ;
            endcase
            if (hdr_last) begin
                n_hcnt     = '0;
                n_plane    = 2'd0;
                n_rows     = n_height;
                n_row_base = '0;
                n_cursor   = '0;
                n_lit      = '0;
                n_phase    = (n_height == 16'd0) ? prsd_pkg::PH_HEADER : prsd_pkg::PH_DECODE;
            end else begin
                n_hcnt = r_hcnt + HC_W'(1);
            end
        end else if (r_lit != 7'd0) begin
            n_cursor = lit_cursor;
            n_lit    = r_lit - 7'd1;
        end else if (i_sprite_byte == 8'd0) begin
            n_rows     = rows_dec;
            n_row_base = base_sat;
            n_cursor   = row_cursor;
            if (plane_end) begin
                if (r_plane == prsd_pkg::LAST_PLANE) begin
                    n_phase = prsd_pkg::PH_HEADER;
                    n_hcnt  = '0;
                    n_lit   = '0;
                end else begin
                    n_plane    = r_plane + 2'd1;
                    n_rows     = r_height;
                    n_row_base = '0;
                    n_cursor   = {30'd0, r_plane + 2'd1};
                    n_lit      = '0;
                end
            end
        end else if (i_sprite_byte[7]) begin
            n_cursor = skip_cursor;
        end else begin
            n_lit = i_sprite_byte[6:0];
        end
    end

    always_comb begin
        res   = '0;
        res_v = 1'b0;
        if (acc) begin
            if (r_phase != prsd_pkg::PH_DECODE) begin
                if (hdr_last && (n_height == 16'd0)) begin
                    res_v           = 1'b1;
                    res.sprite_done = 1'b1;
                end
            end else if (r_lit != 7'd0) begin
                res_v             = 1'b1;
                res.pixel_address = r_cursor[15:0];
                res.pixel_value   = i_sprite_byte;
                res.is_write      = !bad;
                res.out_of_range  = bad;
            end else if (plane_end && (r_plane == prsd_pkg::LAST_PLANE)) begin
                res_v           = 1'b1;
                res.sprite_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= prsd_pkg::PH_HEADER;
            r_hcnt     <= '0;
            r_width    <= '0;
            r_height   <= '0;
            r_plane    <= '0;
            r_rows     <= '0;
            r_row_base <= '0;
            r_cursor   <= '0;
            r_lit      <= '0;
        end else if (acc) begin
            r_phase    <= n_phase;
            r_hcnt     <= n_hcnt;
            r_width    <= n_width;
            r_height   <= n_height;
            r_plane    <= n_plane;
            r_rows     <= n_rows;
            r_row_base <= n_row_base;
            r_cursor   <= n_cursor;
            r_lit      <= n_lit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_limit <= {16'd0, r_width} * {16'd0, r_height};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (out_free) begin
                r_ov <= 1'b1;
                r_sv <= 1'b0;
            end
        end else if (out_free) begin
            r_ov <= res_v;
        end else if (res_v) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (out_free) begin
                r_out <= r_skid;
            end
        end else if (out_free) begin
            r_out <= res;
        end else if (res_v) begin
            r_skid <= res;
        end
    end

    assign o_in_stall      = r_sv;
    assign o_out_valid     = r_ov;
    assign o_pixel_address = r_out.pixel_address;
    assign o_pixel_value   = r_out.pixel_value;
    assign o_is_write      = r_out.is_write;
    assign o_out_of_range  = r_out.out_of_range;
    assign o_sprite_done   = r_out.sprite_done;

    `PRSD_ASSERT_SAME(a_skid_behind_out, i_clk, i_rst_n, r_sv, r_ov,
        "skid register holds a request while the output register is empty")
    `PRSD_ASSERT_SAME(a_done_clean, i_clk, i_rst_n, r_ov && r_out.sprite_done,
        !r_out.is_write && !r_out.out_of_range && (r_out.pixel_address == 16'd0),
        "sprite done request carries pixel data")
    `PRSD_ASSERT_NEXT(a_literal_count, i_clk, i_rst_n,
        acc && (r_phase == prsd_pkg::PH_DECODE) && (r_lit != 7'd0),
        r_lit == $past(r_lit) - 7'd1,
        "literal count did not step down on a literal byte")
    `PRSD_ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n, r_sv && !i_out_stall, !r_sv,
        "skid register not drained after the output was taken")

endmodule
